// ===== hw/rtl/fpa_pkg.sv =====
// Shared constants, operation codes and pipeline flag types of the fixed-point ALU.
package fpa_pkg;

    // Default number format: Q24.8 in a 32-bit word.
    localparam int DEFAULT_FRACTION_BITS = 8;
    localparam int DEFAULT_WORD_BITS     = 32;

    // Fixed widths of the operand and result beats.
    localparam int PORT_BITS = 32;
    localparam int OP_BITS   = 4;

    // Register stages of the pipelined multiplier.
    localparam int MUL_STAGES = 3;

    typedef logic [OP_BITS-1:0] op_t;

    localparam op_t OP_ADD     = 4'd0;
    localparam op_t OP_SUB     = 4'd1;
    localparam op_t OP_MUL     = 4'd2;
    localparam op_t OP_DIV     = 4'd3;
    localparam op_t OP_GT      = 4'd4;
    localparam op_t OP_LT      = 4'd5;
    localparam op_t OP_GE      = 4'd6;
    localparam op_t OP_LE      = 4'd7;
    localparam op_t OP_EQ      = 4'd8;
    localparam op_t OP_NE      = 4'd9;
    localparam op_t OP_MIN     = 4'd10;
    localparam op_t OP_MAX     = 4'd11;
    localparam op_t OP_INC     = 4'd12;
    localparam op_t OP_DEC     = 4'd13;
    localparam op_t OP_TOINT   = 4'd14;
    localparam op_t OP_FROMINT = 4'd15;

    // Flags that travel down the pipeline alongside each operation.
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic q_neg;
        logic div_zero;
        logic cmp;
    } side_t;

endpackage

// ===== hw/rtl/fpa_multiplier.sv =====
// Three-stage signed fixed-point multiplier built from four half-width partial products.
module fpa_multiplier
    import fpa_pkg::*;
#(
    parameter int WORD_BITS     = DEFAULT_WORD_BITS,
    parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
)
(
    input  logic                  clk,
    input  logic [MUL_STAGES-1:0] stage_en,
    input  logic [WORD_BITS-1:0]  mag_a,
    input  logic [WORD_BITS-1:0]  mag_b,
    input  logic                  negate,
    output logic [WORD_BITS-1:0]  product
);

    localparam int HALF_BITS = (WORD_BITS + 1) / 2;
    localparam int PP_BITS   = 2 * HALF_BITS;
    localparam int FULL_BITS = (4 * HALF_BITS > WORD_BITS + FRACTION_BITS) ?
                               4 * HALF_BITS : WORD_BITS + FRACTION_BITS;

    logic [HALF_BITS-1:0] a_lo;
    logic [HALF_BITS-1:0] a_hi;
    logic [HALF_BITS-1:0] b_lo;
    logic [HALF_BITS-1:0] b_hi;

    logic [PP_BITS-1:0]   pp_ll_reg;
    logic [PP_BITS-1:0]   pp_lh_reg;
    logic [PP_BITS-1:0]   pp_hl_reg;
    logic [PP_BITS-1:0]   pp_hh_reg;
    logic                 neg1_reg;

    logic [FULL_BITS-1:0] sum_next;
    logic [FULL_BITS-1:0] sum_reg;
    logic                 neg2_reg;

    logic [FULL_BITS-1:0] signed_prod;
    logic [WORD_BITS-1:0] product_reg;

    // Split both magnitudes into low and high halves.
    assign a_lo = mag_a[HALF_BITS-1:0];
    assign a_hi = HALF_BITS'(mag_a[WORD_BITS-1:HALF_BITS]);
    assign b_lo = mag_b[HALF_BITS-1:0];
    assign b_hi = HALF_BITS'(mag_b[WORD_BITS-1:HALF_BITS]);

    // First stage: the four partial products.
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            pp_ll_reg <= a_lo * b_lo;
            pp_lh_reg <= a_lo * b_hi;
            pp_hl_reg <= a_hi * b_lo;
            pp_hh_reg <= a_hi * b_hi;
            neg1_reg  <= negate;
        end
    end

    // Second stage: weight and add the partial products into the full magnitude.
    assign sum_next = (FULL_BITS'(pp_hh_reg) << PP_BITS)
                    + ((FULL_BITS'(pp_lh_reg) + FULL_BITS'(pp_hl_reg)) << HALF_BITS)
                    + FULL_BITS'(pp_ll_reg);

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            sum_reg  <= sum_next;
            neg2_reg <= neg1_reg;
        end
    end

    // Third stage: apply the sign, then a part-select above the fraction bits picks the result bits.
    assign signed_prod = neg2_reg ? (~sum_reg + FULL_BITS'(1)) : sum_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            product_reg <= signed_prod[FRACTION_BITS +: WORD_BITS];
        end
    end

    assign product = product_reg;

endmodule

// ===== hw/rtl/fpa_divider.sv =====
// Pipelined restoring divider of magnitudes, one quotient bit per register stage.
module fpa_divider
    import fpa_pkg::*;
#(
    parameter int WORD_BITS     = DEFAULT_WORD_BITS,
    parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
)
(
    input  logic                                clk,
    input  logic [WORD_BITS+FRACTION_BITS-1:0] stage_en,
    input  logic [WORD_BITS+FRACTION_BITS-1:0] dividend,
    input  logic [WORD_BITS-1:0]               divisor,
    output logic [WORD_BITS-1:0]               quotient
);

    localparam int DIV_BITS = WORD_BITS + FRACTION_BITS;

    // One set of registers per quotient bit.
    logic [WORD_BITS-1:0] rem_reg [DIV_BITS];
    logic [DIV_BITS-1:0]  dvd_reg [DIV_BITS];
    logic [WORD_BITS-1:0] dsr_reg [DIV_BITS];
    logic [WORD_BITS-1:0] quo_reg [DIV_BITS];

    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_step
        logic [WORD_BITS-1:0] rem_prev;
        logic [DIV_BITS-1:0]  dvd_prev;
        logic [WORD_BITS-1:0] dsr_prev;
        logic [WORD_BITS-1:0] quo_prev;
        logic [WORD_BITS:0]   trial;
        logic [WORD_BITS:0]   diff;
        logic                 fits;

        // The first step starts from a clear remainder.
        if (k == 0)
        begin : g_first
            assign rem_prev = '0;
            assign dvd_prev = dividend;
            assign dsr_prev = divisor;
            assign quo_prev = '0;
        end
        else
        begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign dvd_prev = dvd_reg[k-1];
            assign dsr_prev = dsr_reg[k-1];
            assign quo_prev = quo_reg[k-1];
        end

        // Bring down the next dividend bit and try the subtraction.
        assign trial = {rem_prev, dvd_prev[DIV_BITS-1]};
        assign diff  = trial - {1'b0, dsr_prev};
        assign fits  = ~diff[WORD_BITS];

        // Only the low word of the quotient is kept, as the result wraps.
        always_ff @(posedge clk)
        begin
            if (stage_en[k])
            begin
                rem_reg[k] <= fits ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
                dvd_reg[k] <= dvd_prev << 1;
                dsr_reg[k] <= dsr_prev;
                quo_reg[k] <= {quo_prev[WORD_BITS-2:0], fits};
            end
        end
    end

    assign quotient = quo_reg[DIV_BITS-1];

endmodule

// ===== hw/rtl/fixed_point_alu.sv =====
// Top level of the pipelined signed fixed-point ALU.
//
//   Channel   Handshake                      Payload
//   operand   operand_valid / operand_ready  operation, operand_a, operand_b
//   result    result_valid / result_ready    result_word, compare_true, divide_by_zero
//
// The depth from operand beat to result beat is set by the divider, which resolves
// one quotient bit per stage (Q24.8 is the default format); all operations share
// that depth, so results leave in order.
// One operand beat is taken per cycle while operand_ready is high. A stalled result
// holds only the stages that are full: empty stages below it keep filling, so
// operand_ready stays high while any bubble remains. Reset clears the stage valid bits only.
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS,
    parameter int WORD_BITS     = DEFAULT_WORD_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        operand_valid,
    output logic                        operand_ready,
    input  logic [OP_BITS-1:0]          operation,
    input  logic signed [PORT_BITS-1:0] operand_a,
    input  logic signed [PORT_BITS-1:0] operand_b,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic signed [PORT_BITS-1:0] result_word,
    output logic                        compare_true,
    output logic                        divide_by_zero
);

    localparam int DIV_BITS  = WORD_BITS + FRACTION_BITS;
    localparam int STAGES    = DIV_BITS + 3;
    localparam int LAST      = STAGES - 1;
    localparam int MUL_OUT   = 1 + MUL_STAGES;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] stage_en;

    logic signed [WORD_BITS-1:0] a_in;
    logic signed [WORD_BITS-1:0] b_in;

    op_t                         op0_reg;
    logic signed [WORD_BITS-1:0] a0_reg;
    logic signed [WORD_BITS-1:0] b0_reg;

    logic [WORD_BITS-1:0]        addend;
    logic                        subtract;
    logic [WORD_BITS-1:0]        sum;
    logic                        a_lt_b;
    logic                        a_eq_b;
    logic [WORD_BITS-1:0]        simple_next;
    logic                        cmp_next;
    side_t                       side_next;
    logic [WORD_BITS-1:0]        mag_a_next;
    logic [WORD_BITS-1:0]        mag_b_next;

    side_t                       side_reg [1:LAST-1];
    logic [WORD_BITS-1:0]        res_reg  [1:LAST-1];
    logic [WORD_BITS-1:0]        mag_a_reg;
    logic [WORD_BITS-1:0]        mag_b_reg;

    logic [WORD_BITS-1:0]        mul_word;
    logic [WORD_BITS-1:0]        div_quo;
    logic [WORD_BITS-1:0]        word_next;

    logic [WORD_BITS-1:0]        word_reg;
    logic                        cmp_reg;
    logic                        dz_reg;

    // A stage moves on when the result is taken or some stage at or above it is empty.
    always_comb
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            stage_en[i] = result_ready || (|(~valid_reg & ({STAGES{1'b1}} << i)));
        end
    end

    assign operand_ready = stage_en[0];
    assign valid_next    = {valid_reg[STAGES-2:0], operand_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (stage_en[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    // Operands are sign-extended from the port and wrapped to the word width.
    assign a_in = WORD_BITS'({{WORD_BITS{operand_a[PORT_BITS-1]}}, operand_a});
    assign b_in = WORD_BITS'({{WORD_BITS{operand_b[PORT_BITS-1]}}, operand_b});

    // Input register.
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            op0_reg <= operation;
            a0_reg  <= a_in;
            b0_reg  <= b_in;
        end
    end

    // Simple operations, comparisons and operand magnitudes, computed from the input register.
    always_comb
    begin
        subtract = (op0_reg == OP_SUB) || (op0_reg == OP_DEC);
        addend   = ((op0_reg == OP_ADD) || (op0_reg == OP_SUB)) ? b0_reg : WORD_BITS'(1);
        sum      = a0_reg + (subtract ? ~addend : addend) + WORD_BITS'(subtract);
        a_lt_b   = a0_reg < b0_reg;
        a_eq_b   = a0_reg == b0_reg;

        unique case (op0_reg)
            OP_ADD, OP_SUB, OP_INC, OP_DEC: simple_next = sum;
            OP_MIN:     simple_next = a_lt_b ? a0_reg : b0_reg;
            OP_MAX:     simple_next = (!a_lt_b && !a_eq_b) ? a0_reg : b0_reg;
            OP_TOINT:   simple_next = a0_reg >>> FRACTION_BITS;
            OP_FROMINT: simple_next = a0_reg << FRACTION_BITS;
            default:    simple_next = '0;
        endcase

        unique case (op0_reg)
            OP_GT:   cmp_next = !a_lt_b && !a_eq_b;
            OP_LT:   cmp_next = a_lt_b;
            OP_GE:   cmp_next = !a_lt_b;
            OP_LE:   cmp_next = a_lt_b || a_eq_b;
            OP_EQ:   cmp_next = a_eq_b;
            OP_NE:   cmp_next = !a_eq_b;
            default: cmp_next = 1'b0;
        endcase

        side_next.is_mul   = op0_reg == OP_MUL;
        side_next.is_div   = op0_reg == OP_DIV;
        side_next.q_neg    = a0_reg[WORD_BITS-1] ^ b0_reg[WORD_BITS-1];
        side_next.div_zero = (op0_reg == OP_DIV) && (b0_reg == '0);
        side_next.cmp      = cmp_next;

        mag_a_next = a0_reg[WORD_BITS-1] ? (~a0_reg + WORD_BITS'(1)) : a0_reg;
        mag_b_next = b0_reg[WORD_BITS-1] ? (~b0_reg + WORD_BITS'(1)) : b0_reg;
    end

    // Flags and early results ride down the pipeline; the product joins after its stages.
    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            side_reg[1] <= side_next;
            res_reg[1]  <= simple_next;
            mag_a_reg   <= mag_a_next;
            mag_b_reg   <= mag_b_next;
        end
        for (int i = 2; i < LAST; i++)
        begin
            if (stage_en[i])
            begin
                side_reg[i] <= side_reg[i-1];
                if ((i == MUL_OUT + 1) && side_reg[i-1].is_mul)
                begin
                    res_reg[i] <= mul_word;
                end
                else
                begin
                    res_reg[i] <= res_reg[i-1];
                end
            end
        end
    end

    fpa_multiplier #(
        .WORD_BITS     (WORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .clk      (clk),
        .stage_en (stage_en[MUL_OUT:2]),
        .mag_a    (mag_a_reg),
        .mag_b    (mag_b_reg),
        .negate   (side_reg[1].q_neg),
        .product  (mul_word)
    );

    fpa_divider #(
        .WORD_BITS     (WORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .stage_en (stage_en[DIV_BITS+1:2]),
        .dividend ({mag_a_reg, FRACTION_BITS'(0)}),
        .divisor  (mag_b_reg),
        .quotient (div_quo)
    );

    // Output stage: sign the quotient, give zero on a zero divisor, or pass the result carried so far.
    always_comb
    begin
        if (side_reg[LAST-1].is_div)
        begin
            if (side_reg[LAST-1].div_zero)
            begin
                word_next = '0;
            end
            else
            begin
                word_next = side_reg[LAST-1].q_neg ? (~div_quo + WORD_BITS'(1)) : div_quo;
            end
        end
        else
        begin
            word_next = res_reg[LAST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[LAST])
        begin
            word_reg <= word_next;
            cmp_reg  <= side_reg[LAST-1].cmp;
            dz_reg   <= side_reg[LAST-1].div_zero;
        end
    end

    assign result_valid   = valid_reg[LAST];
    assign result_word    = PORT_BITS'({{PORT_BITS{word_reg[WORD_BITS-1]}}, word_reg});
    assign compare_true   = cmp_reg;
    assign divide_by_zero = dz_reg;

endmodule

// ===== hw/rtl/fpa_checker.sv =====
// Port-level assertions for the fixed-point ALU and the bind that attaches them.
module fpa_checker
    import fpa_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        operand_valid,
    input logic                        operand_ready,
    input logic [OP_BITS-1:0]          operation,
    input logic signed [PORT_BITS-1:0] operand_a,
    input logic signed [PORT_BITS-1:0] operand_b,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic signed [PORT_BITS-1:0] result_word,
    input logic                        compare_true,
    input logic                        divide_by_zero
);

    // A result beat is either a comparison or a division, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(compare_true && divide_by_zero))
    else $error("compare_true and divide_by_zero raised on the same result beat");

    // True comparisons carry a zero word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && compare_true) |-> (result_word == '0))
    else $error("comparison beat carries a non-zero result word");

    // Division by zero gives a zero word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && divide_by_zero) |-> (result_word == '0))
    else $error("divide-by-zero beat carries a non-zero result word");

    // A result beat that is not taken stays, unchanged, on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(result_word) && $stable(compare_true)
             && $stable(divide_by_zero)))
    else $error("stalled result beat dropped or changed");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the fixed-point ALU: queued operand beats, in-order result scoreboard.
module testbench
    import fpa_pkg::*;
();

    localparam int FRACTION_BITS = DEFAULT_FRACTION_BITS;
    localparam int DRAIN_CYCLES  = 60;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        op_t                         operation;
        logic signed [PORT_BITS-1:0] a;
        logic signed [PORT_BITS-1:0] b;
    } operand_beat_t;

    typedef struct {
        logic signed [PORT_BITS-1:0] word;
        logic                        cmp;
        logic                        dz;
    } result_beat_t;

    logic                        clk;
    logic                        rst_n;
    logic                        operand_valid;
    logic                        operand_ready;
    logic [OP_BITS-1:0]          operation;
    logic signed [PORT_BITS-1:0] operand_a;
    logic signed [PORT_BITS-1:0] operand_b;
    logic                        result_valid;
    logic                        result_ready;
    logic signed [PORT_BITS-1:0] result_word;
    logic                        compare_true;
    logic                        divide_by_zero;

    operand_beat_t operand_backlog[$];
    result_beat_t  expected_results[$];
    operand_beat_t next_beat;
    result_beat_t  oldest_expected;

    logic operand_taken;
    int   sender_idle_pct;
    int   receiver_idle_pct;
    int   items_queued;
    int   beats_taken;
    int   results_checked;
    int   mismatches;
    int   div_zero_seen;
    int   compares_true_seen;

    fixed_point_alu dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .operand_valid  (operand_valid),
        .operand_ready  (operand_ready),
        .operation      (operation),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result_word    (result_word),
        .compare_true   (compare_true),
        .divide_by_zero (divide_by_zero)
    );

    // Free-running 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Computes the result beat that one operand beat must produce, in 64-bit arithmetic.
    function automatic result_beat_t alu_predict(operand_beat_t beat);
        longint       a;
        longint       b;
        longint       r;
        result_beat_t res;
        a = longint'(beat.a);
        b = longint'(beat.b);
        r = 0;
        res.cmp = 1'b0;
        res.dz  = 1'b0;
        case (beat.operation)
            OP_ADD:     r = a + b;
            OP_SUB:     r = a - b;
            OP_MUL:     r = (a * b) >>> FRACTION_BITS;
            OP_DIV:
            begin
                if (b == 0)
                    res.dz = 1'b1;
                else
                    r = (a * (longint'(1) <<< FRACTION_BITS)) / b;
            end
            OP_GT:      res.cmp = (a > b);
            OP_LT:      res.cmp = (a < b);
            OP_GE:      res.cmp = (a >= b);
            OP_LE:      res.cmp = (a <= b);
            OP_EQ:      res.cmp = (a == b);
            OP_NE:      res.cmp = (a != b);
            OP_MIN:     r = (a < b) ? a : b;
            OP_MAX:     r = (a > b) ? a : b;
            OP_INC:     r = a + 1;
            OP_DEC:     r = a - 1;
            OP_TOINT:   r = a >>> FRACTION_BITS;
            default:    r = a * (longint'(1) <<< FRACTION_BITS);
        endcase
        res.word = r[PORT_BITS-1:0];
        return res;
    endfunction

    // Operand values biased towards the corners: full range, small, extremes, scaled.
    function automatic logic signed [PORT_BITS-1:0] random_operand();
        logic signed [PORT_BITS-1:0] v;
        case ($urandom_range(4))
            0, 1:    v = $urandom;
            2:       v = $urandom_range(2048) - 1024;
            3:
            begin
                case ($urandom_range(4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7fff_ffff;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'h0000_0001;
                    default: v = 32'hffff_ffff;
                endcase
            end
            default:
            begin
                v = $urandom >> $urandom_range(31);
                if ($urandom_range(1) == 1)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic add_item(op_t op, logic signed [PORT_BITS-1:0] a,
                            logic signed [PORT_BITS-1:0] b);
        operand_beat_t beat;
        beat.operation = op;
        beat.a = a;
        beat.b = b;
        operand_backlog.push_back(beat);
        items_queued++;
    endtask

    task automatic add_random_items(int count);
        op_t                         op;
        logic signed [PORT_BITS-1:0] a;
        logic signed [PORT_BITS-1:0] b;
        for (int i = 0; i < count; i++)
        begin
            op = op_t'($urandom_range(15));
            a  = random_operand();
            b  = random_operand();
            // Steer some divides onto a zero divisor and some comparisons, minimums and maximums onto a tie.
            if (op == OP_DIV && $urandom_range(7) == 0)
                b = '0;
            if (op >= OP_GT && op <= OP_MAX && $urandom_range(3) == 0)
                b = a;
            add_item(op, a, b);
        end
    endtask

    task automatic wait_drained();
        while (results_checked != items_queued)
            @(negedge clk);
    endtask

    // Sender: a new beat is offered only once the previous one has been taken; result_ready is also driven here.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            operand_valid <= 1'b0;
        end
        else if (!operand_valid || operand_taken)
        begin
            if (operand_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                next_beat = operand_backlog.pop_front();
                operation     <= next_beat.operation;
                operand_a     <= next_beat.a;
                operand_b     <= next_beat.b;
                operand_valid <= 1'b1;
            end
            else
            begin
                operand_valid <= 1'b0;
            end
        end
        result_ready <= rst_n && ($urandom_range(99) >= receiver_idle_pct);
    end

    // Monitor: check result beats against the oldest prediction, then record new operand beats.
    always @(posedge clk)
    begin
        operand_taken <= operand_valid && operand_ready;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("Unexpected result beat: word %h cmp %b dz %b",
                                 result_word, compare_true, divide_by_zero);
                end
                else
                begin
                    oldest_expected = expected_results.pop_front();
                    results_checked++;
                    if (result_word !== oldest_expected.word
                        || compare_true !== oldest_expected.cmp
                        || divide_by_zero !== oldest_expected.dz)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"Result %0d wrong: expected word %h cmp %b dz %b, ",
                                      "got word %h cmp %b dz %b"},
                                     results_checked, oldest_expected.word,
                                     oldest_expected.cmp, oldest_expected.dz,
                                     result_word, compare_true, divide_by_zero);
                    end
                end
            end
            if (operand_valid && operand_ready)
            begin
                expected_results.push_back(alu_predict('{operation, operand_a, operand_b}));
                beats_taken++;
                if (expected_results[$].dz)
                    div_zero_seen++;
                if (expected_results[$].cmp)
                    compares_true_seen++;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        operand_valid     = 1'b0;
        result_ready      = 1'b0;
        operation         = OP_ADD;
        operand_a         = '0;
        operand_b         = '0;
        operand_taken     = 1'b0;
        items_queued      = 0;
        beats_taken       = 0;
        results_checked   = 0;
        mismatches        = 0;
        div_zero_seen     = 0;
        compares_true_seen = 0;
        sender_idle_pct   = 10;
        receiver_idle_pct = 55;

        // Directed corners: wrap-around, floor shifts, zero divisor, ties and every code.
        add_item(OP_ADD,     32'h7fff_ffff, 32'h0000_0001);
        add_item(OP_ADD,     32'h0000_0000, 32'h0000_0000);
        add_item(OP_SUB,     32'h8000_0000, 32'h0000_0001);
        add_item(OP_MUL,     32'h7fff_ffff, 32'h7fff_ffff);
        add_item(OP_MUL,     32'h8000_0000, 32'h8000_0000);
        add_item(OP_MUL,     32'hffff_ffff, 32'h0000_0001);
        add_item(OP_DIV,     32'h0000_1234, 32'h0000_0000);
        add_item(OP_DIV,     32'h0000_0000, 32'h0000_0000);
        add_item(OP_DIV,     32'h8000_0000, 32'hffff_ffff);
        add_item(OP_DIV,     32'hffff_ffff, 32'h0000_0003);
        add_item(OP_GT,      32'h8000_0000, 32'h7fff_ffff);
        add_item(OP_LT,      32'h8000_0000, 32'h7fff_ffff);
        add_item(OP_GE,      32'h0000_0100, 32'h0000_0100);
        add_item(OP_LE,      32'h7fff_ffff, 32'h8000_0000);
        add_item(OP_EQ,      32'hffff_ffff, 32'hffff_ffff);
        add_item(OP_NE,      32'h0000_0000, 32'h8000_0000);
        add_item(OP_MIN,     32'h0000_0005, 32'h0000_0005);
        add_item(OP_MIN,     32'h8000_0000, 32'h7fff_ffff);
        add_item(OP_MAX,     32'h8000_0000, 32'h7fff_ffff);
        add_item(OP_INC,     32'h7fff_ffff, 32'h5555_5555);
        add_item(OP_DEC,     32'h8000_0000, 32'haaaa_aaaa);
        add_item(OP_TOINT,   32'hffff_ffff, 32'h0000_0000);
        add_item(OP_TOINT,   32'h8000_0000, 32'hffff_ffff);
        add_item(OP_FROMINT, 32'hffff_ffff, 32'h0000_0000);
        add_item(OP_FROMINT, 32'h7fff_ffff, 32'h0000_0000);
        add_random_items(620);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Phase one: light sender gaps, heavy result back-pressure.
        wait_drained();

        // Phase two: the other way round.
        sender_idle_pct   = 55;
        receiver_idle_pct = 10;
        add_random_items(640);
        wait_drained();

        // Phase three: full rate on both sides.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        add_random_items(640);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            mismatches++;

        $display("Checked %0d results from %0d operand beats over three idling patterns.",
                 results_checked, beats_taken);
        $display("Among them %0d divide-by-zero results and %0d true comparisons; %0d errors.",
                 div_zero_seen, compares_true_seen, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d of %0d results checked.", results_checked, items_queued);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
